// ----- design/mlm_pkg.sv -----
// Shared constants and controller/datapath interface types of the limb multiplier.
package mlm_pkg;

  localparam int N_LIMBS_DEF = 8;
  localparam int LIMB_W      = 26;
  localparam int RES_W       = 5;
  localparam logic [RES_W-1:0] RES_RESET = RES_W'(16);

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic load_we;
    logic clear;
    logic tok_valid;
    logic tok_end;
    logic tok_zero;
    logic tok_above;
    logic out_load;
    logic out_last;
  } mlm_cmd_t;

  typedef struct packed {
    logic out_free;
  } mlm_sts_t;

endpackage

// ----- design/multiprecision_limb_multiplier.sv -----
// Top level of the radix 2^26 multiprecision limb multiplier.
// Usage:
//   Input stream: N_LIMBS transactions, each carrying one 26-bit limb of x and
//   one of y, least significant first. The transaction that completes both
//   operands starts the multiplication; no input is taken until the product
//   has been handed to the output register.
//   Output stream: min(max(result_limbs,1), 2*N_LIMBS) transactions, low limb
//   first; tlast marks the final limb, tuser[0] on it flags a nonzero
//   dropped upper limb.
//   Sequence: the operand limbs are stored as they arrive. One 26x26 multiplier
//   computes the product column by column, and its pipeline is then drained.
//   Each result limb is then read from the product store and loaded into the
//   output register.
//   A stalled receiver holds the output register; emission waits for it.
//   Reset clears the load count and the output valid and sets result_limbs
//   to 16. cfg_we writes result_limbs in any cycle.
module multiprecision_limb_multiplier #(
  parameter int N_LIMBS = mlm_pkg::N_LIMBS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mlm_pkg::IN_DATA_W-1:0]  in_tdata,   // x_limb, y_limb
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mlm_pkg::OUT_DATA_W-1:0] out_tdata,  // product_limb
  output logic                           out_tlast,
  output logic [0:0]                     out_tuser,  // dropped_nonzero
  input  logic                           cfg_we,
  input  logic [mlm_pkg::RES_W-1:0]      cfg_wdata
);
  import mlm_pkg::*;

  localparam int P  = 2 * N_LIMBS;
  localparam int IW = (N_LIMBS > 1) ? $clog2(N_LIMBS) : 1;
  localparam int CW = $clog2(P);

  logic [RES_W-1:0]  res_r;
  mlm_cmd_t          cmd;
  mlm_sts_t          sts;
  logic [IW-1:0]     ld_addr, x_addr, y_addr;
  logic [CW-1:0]     col_addr, rd_addr;
  logic [LIMB_W-1:0] product_limb;
  logic              dropped_nonzero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= RES_RESET;
    end else if (cfg_we) begin
      res_r <= cfg_wdata;
    end
  end

  mlm_ctrl #(.N_LIMBS(N_LIMBS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .cfg_res(res_r), .sts(sts), .cmd(cmd), .ld_addr(ld_addr),
    .x_addr(x_addr), .y_addr(y_addr), .col_addr(col_addr), .rd_addr(rd_addr)
  );

  mlm_dp #(.N_LIMBS(N_LIMBS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .x_limb(in_tdata[LIMB_W-1:0]), .y_limb(in_tdata[2*LIMB_W-1:LIMB_W]),
    .cmd(cmd), .ld_addr(ld_addr), .x_addr(x_addr), .y_addr(y_addr),
    .col_addr(col_addr), .rd_addr(rd_addr), .sts(sts),
    .out_tready(out_tready), .out_tvalid(out_tvalid),
    .product_limb(product_limb), .last_limb(out_tlast),
    .dropped_nonzero(dropped_nonzero)
  );

  assign out_tdata    = OUT_DATA_W'(product_limb);
  assign out_tuser[0] = dropped_nonzero;

endmodule

// ----- design/mlm_ram.sv -----
// Generic simple dual-port RAM with registered read.
module mlm_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/mlm_ctrl.sv -----
// Sequencer: operand loading, column-wise product schedule and limb emission.
module mlm_ctrl #(
  parameter int N_LIMBS = mlm_pkg::N_LIMBS_DEF,
  localparam int P  = 2 * N_LIMBS,
  localparam int IW = (N_LIMBS > 1) ? $clog2(N_LIMBS) : 1,
  localparam int CW = $clog2(P),
  localparam int EW = $clog2(P + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [mlm_pkg::RES_W-1:0] cfg_res,
  input  mlm_pkg::mlm_sts_t         sts,
  output mlm_pkg::mlm_cmd_t         cmd,
  output logic [IW-1:0]             ld_addr,
  output logic [IW-1:0]             x_addr,
  output logic [IW-1:0]             y_addr,
  output logic [CW-1:0]             col_addr,
  output logic [CW-1:0]             rd_addr
);
  import mlm_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_CALC, S_DRAIN1, S_DRAIN2, S_EMIT, S_CAP
  } state_t;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [IW-1:0]   i_r, i_nxt;
  logic [EW-1:0]   emit_r, emit_nxt;
  logic [CW-1:0]   oidx_r, oidx_nxt;
  logic [EW-1:0]   emit_calc;
  logic [CW-1:0]   col_inc;
  logic [CW-1:0]   j_full;
  logic            last_col;
  logic            tok_end;
  logic            out_last;

  function automatic logic [IW-1:0] hi_of(input logic [CW-1:0] k);
    if (int'(k) < N_LIMBS) begin
      return IW'(k);
    end
    return IW'(N_LIMBS - 1);
  endfunction

  function automatic logic [IW-1:0] lo_of(input logic [CW-1:0] k);
    if (int'(k) >= N_LIMBS) begin
      return IW'(int'(k) - N_LIMBS + 1);
    end
    return '0;
  endfunction

  always_comb begin
    if (cfg_res == '0) begin
      emit_calc = EW'(1);
    end else if (int'(cfg_res) > P) begin
      emit_calc = EW'(P);
    end else begin
      emit_calc = EW'(cfg_res);
    end
  end

  assign col_inc  = col_r + CW'(1);
  assign j_full   = col_r - CW'(i_r);
  assign last_col = (col_r == CW'(P - 1));
  assign tok_end  = last_col || (i_r == hi_of(col_r));
  assign out_last = ((EW'(oidx_r) + EW'(1)) == emit_r);

  assign ld_addr  = cnt_r;
  assign x_addr   = i_r;
  assign y_addr   = j_full[IW-1:0];
  assign col_addr = col_r;
  assign rd_addr  = oidx_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    i_nxt     = i_r;
    emit_nxt  = emit_r;
    oidx_nxt  = oidx_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_we = 1'b1;
          if (cnt_r == IW'(N_LIMBS - 1)) begin
            cmd.clear = 1'b1;
            cnt_nxt   = '0;
            emit_nxt  = emit_calc;
            col_nxt   = '0;
            i_nxt     = '0;
            state_nxt = S_CALC;
          end else begin
            cnt_nxt = cnt_r + IW'(1);
          end
        end
      end
      S_CALC: begin
        cmd.tok_valid = 1'b1;
        cmd.tok_end   = tok_end;
        cmd.tok_zero  = last_col;
        cmd.tok_above = (EW'(col_r) >= emit_r);
        if (tok_end) begin
          if (last_col) begin
            oidx_nxt  = '0;
            state_nxt = S_DRAIN1;
          end else begin
            col_nxt = col_inc;
            i_nxt   = lo_of(col_inc);
          end
        end else begin
          i_nxt = i_r + IW'(1);
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          state_nxt = S_CAP;
        end
      end
      S_CAP: begin
        cmd.out_load = 1'b1;
        cmd.out_last = out_last;
        if (out_last) begin
          state_nxt = S_LOAD;
        end else begin
          oidx_nxt  = oidx_r + CW'(1);
          state_nxt = S_EMIT;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      col_r   <= '0;
      i_r     <= '0;
      emit_r  <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      i_r     <= i_nxt;
      emit_r  <= emit_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

endmodule

// ----- design/mlm_dp.sv -----
// Datapath: operand stores, limb multiplier, column accumulator, product store, output register.
module mlm_dp #(
  parameter int N_LIMBS = mlm_pkg::N_LIMBS_DEF,
  localparam int P  = 2 * N_LIMBS,
  localparam int IW = (N_LIMBS > 1) ? $clog2(N_LIMBS) : 1,
  localparam int CW = $clog2(P)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mlm_pkg::LIMB_W-1:0] x_limb,
  input  logic [mlm_pkg::LIMB_W-1:0] y_limb,
  input  mlm_pkg::mlm_cmd_t          cmd,
  input  logic [IW-1:0]              ld_addr,
  input  logic [IW-1:0]              x_addr,
  input  logic [IW-1:0]              y_addr,
  input  logic [CW-1:0]              col_addr,
  input  logic [CW-1:0]              rd_addr,
  output mlm_pkg::mlm_sts_t          sts,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [mlm_pkg::LIMB_W-1:0] product_limb,
  output logic                       last_limb,
  output logic                       dropped_nonzero
);
  import mlm_pkg::*;

  localparam int PW = 2 * LIMB_W;
  localparam int AW = PW + $clog2(N_LIMBS) + 2;

  logic [LIMB_W-1:0] xd, yd, pd;
  logic              v1_r, end1_r, zero1_r, above1_r;
  logic [CW-1:0]     col1_r;
  logic              v2_r, end2_r, above2_r;
  logic [CW-1:0]     col2_r;
  logic [PW-1:0]     p_r, p_nxt;
  logic [AW-1:0]     acc_r, sum;
  logic              drop_r;
  logic              pwe;
  logic              out_valid_r;
  logic [LIMB_W-1:0] out_limb_r;
  logic              out_last_r, out_drop_r;

  mlm_ram #(.WIDTH(LIMB_W), .DEPTH(N_LIMBS)) u_xram (
    .clk(clk), .we(cmd.load_we), .waddr(ld_addr), .wdata(x_limb),
    .raddr(x_addr), .rdata(xd)
  );

  mlm_ram #(.WIDTH(LIMB_W), .DEPTH(N_LIMBS)) u_yram (
    .clk(clk), .we(cmd.load_we), .waddr(ld_addr), .wdata(y_limb),
    .raddr(y_addr), .rdata(yd)
  );

  assign sum = acc_r + AW'(p_r);
  assign pwe = v2_r && end2_r;

  mlm_ram #(.WIDTH(LIMB_W), .DEPTH(P)) u_pram (
    .clk(clk), .we(pwe), .waddr(col2_r), .wdata(sum[LIMB_W-1:0]),
    .raddr(rd_addr), .rdata(pd)
  );

  assign p_nxt = zero1_r ? '0 : xd * yd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.tok_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    end1_r   <= cmd.tok_end;
    zero1_r  <= cmd.tok_zero;
    above1_r <= cmd.tok_above;
    col1_r   <= col_addr;
    end2_r   <= end1_r;
    above2_r <= above1_r;
    col2_r   <= col1_r;
    p_r      <= p_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      acc_r  <= '0;
      drop_r <= 1'b0;
    end else if (v2_r) begin
      if (end2_r) begin
        acc_r <= sum >> LIMB_W;
        if (above2_r && (sum[LIMB_W-1:0] != '0)) begin
          drop_r <= 1'b1;
        end
      end else begin
        acc_r <= sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_limb_r <= pd;
      out_last_r <= cmd.out_last;
      out_drop_r <= cmd.out_last && drop_r;
    end
  end

  assign sts.out_free    = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign product_limb    = out_limb_r;
  assign last_limb       = out_last_r;
  assign dropped_nonzero = out_drop_r;

endmodule

// ----- design/mlm_chk.sv -----
// Port-level checker of the limb multiplier, bound to the top level.
module mlm_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [mlm_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast,
  input logic [0:0]                     out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("dropped flag on a limb that is not the last");

  a_no_load_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken while product limbs still pending");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind multiprecision_limb_multiplier mlm_chk u_mlm_chk (.*);

// ----- tb/mlm_product_checker.sv -----
// Checker that predicts the limb product of each operand set and compares the output stream.
`timescale 1ns / 100ps
module mlm_product_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [mlm_pkg::IN_DATA_W-1:0]  in_tdata,   // x_limb, y_limb
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [mlm_pkg::OUT_DATA_W-1:0] out_tdata,  // product_limb
  input  logic                           out_tlast,
  input  logic [0:0]                     out_tuser,  // dropped_nonzero
  input  logic                           cfg_we,
  input  logic [mlm_pkg::RES_W-1:0]      cfg_wdata,
  output int                             pending,
  output int                             fail_count
);
  import mlm_pkg::*;

  localparam int NL          = N_LIMBS_DEF;
  localparam int PL          = 2 * NL;

  typedef struct packed {
    logic [LIMB_W-1:0] limb;
    logic              last;
    logic              dropped;
  } limb_result_t;

  logic [LIMB_W-1:0] x_store [NL];
  logic [LIMB_W-1:0] y_store [NL];
  int                loaded;
  logic [RES_W-1:0]  res_limbs;
  limb_result_t      expected_limbs [$];
  int                errors = 0;

  function automatic void report(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: %s: expected %h, actual %h", $time, what, want, got);
  endfunction

  function automatic void queue_product_limbs();
    logic [NL*LIMB_W-1:0] xa;
    logic [NL*LIMB_W-1:0] ya;
    logic [PL*LIMB_W-1:0] prod;
    int                   emit;
    logic                 dropped;
    limb_result_t         r;
    for (int i = 0; i < NL; i++) begin
      xa[i*LIMB_W +: LIMB_W] = x_store[i];
      ya[i*LIMB_W +: LIMB_W] = y_store[i];
    end
    prod = xa;
    prod = prod * ya;
    emit = (res_limbs == 0) ? 1 : (int'(res_limbs) > PL) ? PL : int'(res_limbs);
    dropped = 1'b0;
    for (int k = emit; k < PL; k++)
      if (prod[k*LIMB_W +: LIMB_W] != '0) dropped = 1'b1;
    for (int i = 0; i < emit; i++) begin
      r.limb    = prod[i*LIMB_W +: LIMB_W];
      r.last    = (i == emit - 1);
      r.dropped = r.last & dropped;
      expected_limbs.push_back(r);
    end
  endfunction

  function automatic void check_limb();
    limb_result_t want;
    if (expected_limbs.size() == 0) begin
      report("unexpected product limb", '0, out_tdata);
      return;
    end
    want = expected_limbs.pop_front();
    if (out_tdata != {{(OUT_DATA_W-LIMB_W){1'b0}}, want.limb})
      report("product_limb", 32'(want.limb), out_tdata);
    if (out_tlast != want.last)
      report("last_limb", 32'(want.last), 32'(out_tlast));
    if (out_tuser[0] != want.dropped)
      report("dropped_nonzero", 32'(want.dropped), 32'(out_tuser[0]));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      loaded    = 0;
      res_limbs = RES_RESET;
      expected_limbs.delete();
    end else begin
      if (out_tvalid && out_tready) check_limb();
      if (in_tvalid && in_tready) begin
        x_store[loaded] = in_tdata[LIMB_W-1:0];
        y_store[loaded] = in_tdata[2*LIMB_W-1:LIMB_W];
        loaded++;
        if (loaded == NL) begin
          loaded = 0;
          queue_product_limbs();
        end
      end
      if (cfg_we) res_limbs = cfg_wdata;
    end
    pending    <= expected_limbs.size();
    fail_count <= errors;
  end

endmodule

// ----- tb/tb_multiprecision_limb_multiplier.sv -----
// Testbench top: drives operand sets and result lengths into the limb multiplier and gives the verdict.
`timescale 1ns / 100ps
module tb_multiprecision_limb_multiplier;
  import mlm_pkg::*;

  localparam int NL       = N_LIMBS_DEF;
  localparam int SETTLE   = NL * NL + 4 * NL + 16;
  localparam int HOLD_OFF = 400;
  localparam int SETS_PER_PHASE = 5;
  localparam logic [LIMB_W-1:0] LIMB_MAX = '1;

  typedef logic [LIMB_W-1:0] limb_set_t [NL];
  typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic [0:0]            out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [RES_W-1:0]      cfg_wdata  = '0;
  logic                  hold_req   = 1'b0;

  int       pending;
  int       fail_count;
  int       burst_left = 0;
  logic     hold_done  = 1'b0;
  int       hold_left  = 0;
  int       mode_left  = 0;
  rx_mode_t rx_mode    = RX_FREE;

  always #4 clk = ~clk;

  multiprecision_limb_multiplier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  mlm_product_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // receiver: one long hold-off on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:   out_tready <= 1'b1;
        RX_HALF:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= ~out_tready;
      endcase
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic send_limbs(input logic [LIMB_W-1:0] xl, input logic [LIMB_W-1:0] yl);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-2*LIMB_W){1'b0}}, yl, xl};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic send_operands(input limb_set_t xs, input limb_set_t ys);
    for (int i = 0; i < NL; i++) send_limbs(xs[i], ys[i]);
  endtask

  // hold the input until every expected limb has arrived and the block is quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_result_limbs(input logic [RES_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [LIMB_W-1:0] pick_limb(input bit sparse);
    int sel;
    sel = $urandom_range(0, 9);
    if (sparse && sel < 6) return '0;
    case (sel)
      0:       return '0;
      1:       return LIMB_MAX;
      2:       return LIMB_W'(1) << $urandom_range(0, LIMB_W - 1);
      default: return LIMB_W'($urandom);
    endcase
  endfunction

  initial begin
    limb_set_t              xs;
    limb_set_t              ys;
    bit                     sparse;
    logic [RES_W-1:0]       res_values [7];
    res_values = '{5'd1, 5'd17, 5'd8, 5'd15, 5'd2, 5'd30, 5'd0};
    res_values[6] = RES_W'($urandom_range(0, 31));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NL; i++) begin
      xs[i] = LIMB_MAX;
      ys[i] = LIMB_MAX;
    end
    send_operands(xs, ys);

    set_result_limbs('0);
    for (int i = 0; i < NL; i++) ys[i] = i[0] ? LIMB_MAX : '0;
    send_operands(xs, ys);

    set_result_limbs('1);
    for (int i = 0; i < NL; i++) begin
      xs[i] = (i == NL - 1) ? LIMB_MAX : '0;
      ys[i] = (i == 0) ? LIMB_W'(1) : LIMB_MAX;
    end
    send_operands(xs, ys);

    for (int p = 0; p < 7; p++) begin
      set_result_limbs(res_values[p]);
      if (p == 2) hold_req <= 1'b1;
      for (int s = 0; s < SETS_PER_PHASE; s++) begin
        sparse = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < NL; i++) begin
          xs[i] = pick_limb(sparse);
          ys[i] = pick_limb(sparse);
        end
        send_operands(xs, ys);
      end
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
